### hdl/uv_sphere_mesh_generator_assert.svh
// Assertion macros shared by the sphere mesh generator modules.
`ifndef UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`define UV_SPHERE_MESH_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UVS_ASSERT_IMPL(lbl, ante, cons, msg)
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/uvs_pkg.sv
// Types, constants and arithmetic helpers of the sphere mesh generator.
package uvs_pkg;

  localparam int MAX_SEGMENTS = 255;
  localparam int TRIG_BITS    = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int STAGES       = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS    = 2'd0,
    REG_SEG_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    REQ_VERTEX = 1'b0,
    REQ_QUAD   = 1'b1
  } req_t;

  localparam logic [15:0] RADIUS_RST    = 16'd8192;
  localparam logic [7:0]  SEG_COUNT_RST = 8'd32;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [15:0] QUARTER     = 16'(1 << (TRIG_BITS - 2));

  localparam logic [31:0] RCP72 = 32'((64'd1 << 32) / 72);
  localparam logic [31:0] RCP42 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] RCP20 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] RCP6  = 32'((64'd1 << 32) / 6);

  typedef logic [32:0] rcp_tab_t [256];

  typedef struct packed {
    logic [14:0] arg;
    logic        neg;
  } fold_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
  } geo_t;

  typedef struct packed {
    req_t        typ;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [15:0] base;
  } side_t;

  function automatic rcp_tab_t gen_rcp_tab();
    rcp_tab_t    tab;
    logic [32:0] rem;
    logic [32:0] q;
    for (int n = 0; n < 256; n++) begin
      rem = '0;
      q   = '0;
      for (int b = 32; b >= 0; b--) begin
        rem = {rem[31:0], (b == 32)};
        if (n != 0 && rem >= 33'(n)) begin
          rem  = rem - 33'(n);
          q[b] = 1'b1;
        end
      end
      tab[n] = q;
    end
    return tab;
  endfunction

  function automatic fold_t fold(input logic [15:0] p);
    fold_t f;
    f.neg = p[15];
    f.arg = p[14] ? 15'(QUARTER) - {1'b0, p[13:0]} : {1'b0, p[13:0]};
    return f;
  endfunction

  function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b} + 64'h2000_0000;
    return p[61:30];
  endfunction

  function automatic logic [31:0] rcp_mul(input logic [31:0] v, input logic [31:0] m);
    logic [63:0] p;
    p = {32'b0, v} * {32'b0, m};
    return p[63:32];
  endfunction

  function automatic logic [31:0] rcp_fix(input logic [31:0] v, input logic [31:0] q0,
                                          input logic [7:0] d);
    logic [31:0] r;
    r = v - 32'(q0 * {24'b0, d});
    return (r >= {24'b0, d}) ? q0 + 32'd1 : q0;
  endfunction

  function automatic logic [30:0] mag31(input logic [31:0] v);
    logic [31:0] n;
    n = 32'd0 - v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

  function automatic logic [15:0] sat_s16(input logic [16:0] m, input logic neg);
    logic [16:0] n;
    n = 17'd0 - m;
    if (neg) begin
      return (m > 17'd32768) ? 16'h8000 : n[15:0];
    end
    return (m > 17'd32767) ? 16'h7FFF : m[15:0];
  endfunction

endpackage

### hdl/uvs_div.sv
// Two-stage divider by the segment count through a reciprocal table.
module uvs_div (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  logic [23:0] x,
  input  logic [7:0]  n,
  output logic [16:0] q
);
  import uvs_pkg::*;

  localparam rcp_tab_t RCP_TAB = gen_rcp_tab();

  logic [56:0] prod;
  logic [16:0] q0_r;
  logic [23:0] x_r;
  logic [24:0] rem;
  logic [16:0] q_r;

  assign prod = {33'b0, x} * {24'b0, RCP_TAB[n]};
  assign rem  = {1'b0, x_r} - 25'({8'b0, q0_r} * {17'b0, n});

  always_ff @(posedge clk) begin
    if (en_a) begin
      q0_r <= prod[48:32];
      x_r  <= x;
    end
    if (en_b) begin
      q_r <= (rem >= {17'b0, n}) ? q0_r + 17'd1 : q0_r;
    end
  end

  assign q = q_r;

endmodule

### hdl/uvs_sin.sv
// Pipelined Taylor sine over a quarter turn, signed Q30 result.
module uvs_sin (
  input  logic               clk,
  input  logic [13:0]        en,
  input  uvs_pkg::fold_t     arg,
  output logic signed [31:0] y
);
  import uvs_pkg::*;

  logic [45:0] p0;
  logic [30:0] x_r  [13];
  logic        neg_r [13];
  logic [31:0] x2_r [1:9];
  logic [31:0] q2_r, t3_r, m4_r, q5_r, m5_r, t6_r, m7_r, q8_r, m8_r, t9_r;
  logic [31:0] m10_r, q11_r, m11_r, t12_r;
  logic [31:0] fin;
  logic [31:0] fin_c;
  logic signed [31:0] y_r;

  assign p0    = {31'b0, arg.arg} * {15'b0, HALF_PI_Q30} + 46'd8192;
  assign fin   = mul_q30({1'b0, x_r[12]}, t12_r);
  assign fin_c = (fin > Q30_ONE) ? Q30_ONE : fin;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]   <= p0[44:14];
      neg_r[0] <= arg.neg;
    end
    for (int k = 1; k <= 12; k++) begin
      if (en[k]) begin
        x_r[k]   <= x_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
    if (en[1]) x2_r[1] <= mul_q30({1'b0, x_r[0]}, {1'b0, x_r[0]});
    for (int k = 2; k <= 9; k++) begin
      if (en[k]) x2_r[k] <= x2_r[k-1];
    end
    if (en[2])  q2_r  <= rcp_mul(x2_r[1], RCP72);
    if (en[3])  t3_r  <= Q30_ONE - rcp_fix(x2_r[2], q2_r, 8'd72);
    if (en[4])  m4_r  <= mul_q30(x2_r[3], t3_r);
    if (en[5]) begin
      q5_r <= rcp_mul(m4_r, RCP42);
      m5_r <= m4_r;
    end
    if (en[6])  t6_r  <= Q30_ONE - rcp_fix(m5_r, q5_r, 8'd42);
    if (en[7])  m7_r  <= mul_q30(x2_r[6], t6_r);
    if (en[8]) begin
      q8_r <= rcp_mul(m7_r, RCP20);
      m8_r <= m7_r;
    end
    if (en[9])  t9_r  <= Q30_ONE - rcp_fix(m8_r, q8_r, 8'd20);
    if (en[10]) m10_r <= mul_q30(x2_r[9], t9_r);
    if (en[11]) begin
      q11_r <= rcp_mul(m10_r, RCP6);
      m11_r <= m10_r;
    end
    if (en[12]) t12_r <= Q30_ONE - rcp_fix(m11_r, q11_r, 8'd6);
    if (en[13]) y_r   <= neg_r[12] ? -$signed(fin_c) : $signed(fin_c);
  end

  assign y = y_r;

endmodule

### hdl/uvs_scale.sv
// Direction products, radius scaling and normal rounding.
module uvs_scale (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic [15:0]        radius,
  input  logic signed [31:0] sp,
  input  logic signed [31:0] cp,
  input  logic signed [31:0] st,
  input  logic signed [31:0] ct,
  output uvs_pkg::geo_t      geo
);
  import uvs_pkg::*;

  function automatic logic [15:0] pos_of(input logic [15:0] r, input logic [31:0] v);
    logic [46:0] pp;
    pp = {31'b0, r} * {16'b0, mag31(v)} + 47'h2000_0000;
    return sat_s16(pp[46:30], v[31]);
  endfunction

  function automatic logic [15:0] norm_of(input logic [31:0] v);
    logic [31:0] s;
    s = {1'b0, mag31(v)} + 32'h4000;
    return sat_s16(s[31:15], v[31]);
  endfunction

  logic [31:0] mx, mz;
  logic [31:0] dx_r, dz_r, cp_r;
  geo_t        geo_r;

  assign mx = mul_q30({1'b0, mag31(sp)}, {1'b0, mag31(ct)});
  assign mz = mul_q30({1'b0, mag31(sp)}, {1'b0, mag31(st)});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= (sp[31] ^ ct[31]) ? 32'd0 - mx : mx;
      dz_r <= (sp[31] ^ st[31]) ? 32'd0 - mz : mz;
      cp_r <= cp;
    end
    if (en[1]) begin
      geo_r.pos_x  <= pos_of(radius, dx_r);
      geo_r.pos_y  <= pos_of(radius, cp_r);
      geo_r.pos_z  <= pos_of(radius, dz_r);
      geo_r.norm_x <= norm_of(dx_r);
      geo_r.norm_y <= norm_of(cp_r);
      geo_r.norm_z <= norm_of(dz_r);
    end
  end

  assign geo = geo_r;

endmodule

### hdl/uvs_out.sv
// Output register that sends one vertex item or two triangle items.
`include "uv_sphere_mesh_generator_assert.svh"
module uvs_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  uvs_pkg::geo_t  geo,
  input  uvs_pkg::side_t side,
  input  logic [7:0]     n,
  output logic           load_ok,
  output logic           out_tvalid,
  input  logic           out_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z, tri_a, tri_b, tri_c
  output logic [175:0]   out_tdata,
  output logic           out_tlast
);
  import uvs_pkg::*;

  logic        ov_r, last_r;
  geo_t        geo_r;
  logic [15:0] tex_u_r, tex_v_r, tri_a_r, tri_b_r, tri_c_r;
  logic        ld, adv, quad;

  assign load_ok = !ov_r || (out_tready && last_r);
  assign ld      = load_ok && in_valid;
  assign adv     = ov_r && out_tready && !last_r;
  assign quad    = (side.typ == REQ_QUAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      last_r <= 1'b0;
    end else if (load_ok) begin
      ov_r <= in_valid;
      if (in_valid) last_r <= !quad;
    end else if (adv) begin
      last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      geo_r   <= quad ? '0 : geo;
      tex_u_r <= quad ? 16'd0 : side.tex_u;
      tex_v_r <= quad ? 16'd0 : side.tex_v;
      tri_a_r <= quad ? side.base : 16'd0;
      tri_b_r <= quad ? side.base + 16'd1 : 16'd0;
      tri_c_r <= quad ? side.base + {8'b0, n} + 16'd1 : 16'd0;
    end else if (adv) begin
      tri_a_r <= tri_b_r;
      tri_b_r <= tri_c_r + 16'd1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {tri_c_r, tri_b_r, tri_a_r, geo_r.norm_z, geo_r.norm_y, geo_r.norm_x,
                       tex_v_r, tex_u_r, geo_r.pos_z, geo_r.pos_y, geo_r.pos_x};

  `UVS_ASSERT_NEXT(a_second_tri, ov_r && out_tready && !last_r, ov_r && last_r, "second triangle missing")
  `UVS_ASSERT_IMPL(a_first_tri, ov_r && !last_r, tri_b_r == tri_a_r + 16'd1, "first triangle indices")
  `UVS_ASSERT_NEXT(a_shared_edge, ov_r && out_tready && !last_r, tri_a_r == $past(tri_b_r), "shared edge lost")

endmodule

### hdl/uv_sphere_mesh_generator.sv
// UV sphere mesh generator top level: input stage, dividers, sine lanes, output.
// Accepts one item per cycle into a 19-stage pipeline while no stall holds it. A vertex request
// gives one result item, a quad request gives two triangle items one after the other, so the
// output port sets the sustained rate. Stalls backpressure stage by stage.
`include "uv_sphere_mesh_generator_assert.svh"
module uv_sphere_mesh_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // ring, segment
  input  logic [15:0]                   in_tdata,
  // req_type
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z, tri_a, tri_b, tri_c
  output logic [175:0]                  out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import uvs_pkg::*;

  logic [15:0]        radius_r;
  logic [7:0]         seg_count_r;
  logic [7:0]         n;
  logic [STAGES-1:0]  v_r;
  logic [STAGES-1:0]  en;
  logic               load_ok;
  logic [7:0]         lim, in_ring, in_seg;
  req_t               typ0_r, typ1_r, typ2_r;
  logic [7:0]         ring0_r, seg0_r;
  logic [15:0]        base1_r, base2_r;
  logic [8:0]         n1;
  logic [16:0]        bprod;
  logic [7:0]         half;
  logic [23:0]        x_th, x_ph, x_u, x_v;
  logic [16:0]        q_th, q_ph, q_u, q_v;
  side_t              side_r [3:STAGES-1];
  logic signed [31:0] sp, cp, st, ct;
  geo_t               geo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RST;
      seg_count_r <= SEG_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS:    radius_r <= cfg_data;
        REG_SEG_COUNT: seg_count_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign n = (seg_count_r == 8'd0) ? 8'd1 :
             (seg_count_r > 8'(MAX_SEGMENTS)) ? 8'(MAX_SEGMENTS) : seg_count_r;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || load_ok;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ring = in_tdata[7:0];
  assign in_seg  = in_tdata[15:8];
  assign lim     = (in_tuser == REQ_QUAD) ? n - 8'd1 : n;
  assign n1      = {1'b0, n} + 9'd1;
  assign bprod   = {9'b0, ring0_r} * {8'b0, n1};
  assign half    = {1'b0, n[7:1]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      typ0_r  <= req_t'(in_tuser);
      ring0_r <= (in_ring > lim) ? lim : in_ring;
      seg0_r  <= (in_seg > lim) ? lim : in_seg;
    end
    if (en[1]) begin
      typ1_r  <= typ0_r;
      base1_r <= bprod[15:0] + {8'b0, seg0_r};
    end
    if (en[2]) begin
      typ2_r  <= typ1_r;
      base2_r <= base1_r;
    end
    if (en[3]) side_r[3] <= '{typ: typ2_r, tex_u: q_u[15:0], tex_v: q_v[15:0], base: base2_r};
    for (int k = 4; k < STAGES; k++) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
  end

  assign x_th = {seg0_r, 16'b0} + {16'b0, half};
  assign x_ph = {1'b0, ring0_r, 15'b0} + {16'b0, half};
  assign x_u  = {1'b0, n - seg0_r, 15'b0} + {16'b0, half};
  assign x_v  = {1'b0, n - ring0_r, 15'b0} + {16'b0, half};

  uvs_div u_div_th (.clk, .en_a(en[1]), .en_b(en[2]), .x(x_th), .n, .q(q_th));
  uvs_div u_div_ph (.clk, .en_a(en[1]), .en_b(en[2]), .x(x_ph), .n, .q(q_ph));
  uvs_div u_div_u  (.clk, .en_a(en[1]), .en_b(en[2]), .x(x_u),  .n, .q(q_u));
  uvs_div u_div_v  (.clk, .en_a(en[1]), .en_b(en[2]), .x(x_v),  .n, .q(q_v));

  uvs_sin u_sin_sp (.clk, .en(en[16:3]), .arg(fold(q_ph[15:0])), .y(sp));
  uvs_sin u_sin_cp (.clk, .en(en[16:3]), .arg(fold(q_ph[15:0] + QUARTER)), .y(cp));
  uvs_sin u_sin_st (.clk, .en(en[16:3]), .arg(fold(q_th[15:0])), .y(st));
  uvs_sin u_sin_ct (.clk, .en(en[16:3]), .arg(fold(q_th[15:0] + QUARTER)), .y(ct));

  uvs_scale u_scale (
    .clk, .en(en[18:17]), .radius(radius_r), .sp, .cp, .st, .ct, .geo
  );

  uvs_out u_out (
    .clk, .rst_n, .in_valid(v_r[STAGES-1]), .geo, .side(side_r[STAGES-1]), .n,
    .load_ok, .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  `UVS_ASSERT_IMPL(a_free_entry, !v_r[0], in_tready, "input stalled with empty first stage")
  `UVS_ASSERT_NEXT(a_tail_hold, v_r[STAGES-1] && !load_ok, v_r[STAGES-1], "stalled item dropped")
  `UVS_ASSERT_NEXT(a_enter, in_tvalid && in_tready, v_r[0], "accepted item lost")

endmodule
